// ===== hw/rtl/udpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// udpcs_pkg
// Shared types, constants and helpers of the UDP checksum block.
// ----------------------------------------------------------------------------
package udpcs_pkg;

  localparam int          WORD_W          = 16;
  localparam logic [2:0]  CKSUM_FIELD_POS = 3'd3;
  localparam logic [2:0]  POS_SATURATE    = 3'd4;
  localparam logic [15:0] CKSUM_MASK      = 16'hffff;

  // one word after classification, queued between front and back
  typedef struct packed {
    logic              first;
    logic              last;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] phsum;
  } udpcs_entry_t;

  typedef struct packed {
    logic         push;
    udpcs_entry_t entry;
  } udpcs_wr_t;

  typedef struct packed {
    logic              push;
    logic [WORD_W-1:0] checksum;
  } udpcs_res_t;

  // end-around carry, input must stay below 0x1ffff
  function automatic logic [WORD_W-1:0] fold17(input logic [WORD_W:0] v);
    logic [WORD_W:0] s;
    s = {1'b0, v[WORD_W-1:0]} + {{WORD_W{1'b0}}, v[WORD_W]};
    return s[WORD_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/udp_checksum_pseudo_header.sv =====
// ----------------------------------------------------------------------------
// udp_checksum_pseudo_header
// UDP checksum over a streamed segment, pseudo-header included.
// ----------------------------------------------------------------------------
// usage
//   input queue: one 16-bit big-endian segment word per request, written with
//   in_push while in_full is low; the first word also carries the addresses,
//   protocol and length of the pseudo-header; the last word yields a result
//   result queue: out_checksum is valid while out_empty is low, taken by
//   out_pop
//   path: a last word passes the request queue and the back end, and its
//   checksum is registered in the result queue, from which it is popped
//   throughput: one word per cycle while no last word waits on a full
//   result queue; words pass through a MID_DEPTH request queue and
//   results through an OUT_DEPTH result queue
//   reset: both queues are emptied, the running sum and word position clear
//   stall: when the result queue fills, words behind a last word wait in the
//   request queue; once it fills too, in_full rises
// ----------------------------------------------------------------------------
module udp_checksum_pseudo_header
  import udpcs_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_segment_length,
  input  logic [15:0] in_data_word,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic        in_odd_tail,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_checksum
);

  udpcs_wr_t    wr;
  udpcs_entry_t mid_entry;
  logic         mid_empty, mid_pop;
  udpcs_res_t   res;
  logic         res_full;

  udpcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_push),
    .q_full         (in_full),
    .src_addr       (in_src_addr),
    .dst_addr       (in_dst_addr),
    .protocol       (in_protocol),
    .segment_length (in_segment_length),
    .data_word      (in_data_word),
    .first_word     (in_first_word),
    .last_word      (in_last_word),
    .odd_tail       (in_odd_tail),
    .wr             (wr)
  );

  udpcs_fifo #(
    .WIDTH ($bits(udpcs_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wr.push),
    .wdata (wr.entry),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (mid_entry),
    .empty (mid_empty)
  );

  udpcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .entry    (mid_entry),
    .q_empty  (mid_empty),
    .q_pop    (mid_pop),
    .res_full (res_full),
    .res      (res)
  );

  udpcs_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res.push),
    .wdata (res.checksum),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_checksum),
    .empty (out_empty)
  );

endmodule

// ===== hw/rtl/udpcs_fifo.sv =====
// ----------------------------------------------------------------------------
// udpcs_fifo
// Small register queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module udpcs_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/udpcs_front.sv =====
// ----------------------------------------------------------------------------
// udpcs_front
// Tracks the word position, masks the checksum field and the odd tail byte,
// and sums the pseudo-header on the first word of a segment.
// ----------------------------------------------------------------------------
module udpcs_front
  import udpcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  logic        q_full,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  protocol,
  input  logic [15:0] segment_length,
  input  logic [15:0] data_word,
  input  logic        first_word,
  input  logic        last_word,
  input  logic        odd_tail,
  output udpcs_wr_t   wr
);

  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  pos_eff;
  logic [15:0] word_m;
  logic [18:0] ph_raw;
  logic [16:0] ph_f1;
  logic        accept;

  assign accept  = req_valid && !q_full;
  assign pos_eff = first_word ? 3'd0 : pos_r;

  always_comb begin
    word_m = data_word;
    if (last_word && odd_tail) begin
      word_m = {data_word[15:8], 8'h00};
    end
    if (pos_eff == CKSUM_FIELD_POS) begin
      word_m = '0;
    end
  end

  // pseudo-header: addresses, zero and protocol, length
  always_comb begin
    ph_raw = {3'b000, src_addr[31:16]} + {3'b000, src_addr[15:0]}
           + {3'b000, dst_addr[31:16]} + {3'b000, dst_addr[15:0]}
           + {11'd0, protocol} + {3'b000, segment_length};
    ph_f1  = {1'b0, ph_raw[15:0]} + {14'd0, ph_raw[18:16]};
  end

  assign pos_nxt = (pos_eff < POS_SATURATE) ? pos_eff + 3'd1 : pos_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    wr.push        = req_valid;
    wr.entry.first = first_word;
    wr.entry.last  = last_word;
    wr.entry.word  = word_m;
    wr.entry.phsum = fold17(ph_f1);
  end

endmodule

// ===== hw/rtl/udpcs_back.sv =====
// ----------------------------------------------------------------------------
// udpcs_back
// Running ones-complement sum with end-around carry; emits the complemented
// sum on the last word of a segment.
// ----------------------------------------------------------------------------
module udpcs_back
  import udpcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  udpcs_entry_t entry,
  input  logic         q_empty,
  output logic         q_pop,
  input  logic         res_full,
  output udpcs_res_t   res
);

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] acc;
  logic [16:0] raw;
  logic        go;

  assign go      = !q_empty && (!entry.last || !res_full);
  assign acc     = entry.first ? entry.phsum : sum_r;
  assign raw     = {1'b0, acc} + {1'b0, entry.word};
  assign sum_nxt = fold17(raw);
  assign q_pop   = go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (go) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    res.push     = go && entry.last;
    res.checksum = ~sum_nxt & CKSUM_MASK;
  end

endmodule

// ===== hw/rtl/udpcs_checker.sv =====
// ----------------------------------------------------------------------------
// udpcs_checker
// Port-level checks of the UDP checksum block, bound to the top level.
// ----------------------------------------------------------------------------
module udpcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_checksum
);

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // reset frees the request queue
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("request queue full after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_checksum)))
    else $error("waiting result changed or dropped");

  // full only rises after a request was pushed
  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("request queue filled without a request");

endmodule

bind udp_checksum_pseudo_header udpcs_checker u_udpcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_checksum (out_checksum)
);

// ===== tb/udp_checksum_pseudo_header_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_checksum_pseudo_header_check
// Watches both queue sides of the UDP checksum block, predicts each checksum
// from the accepted words and compares it with the checksum that is popped.
// ----------------------------------------------------------------------------
module udp_checksum_pseudo_header_check
  import udpcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_segment_length,
  input  logic [15:0] in_data_word,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic        in_odd_tail,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [15:0] out_checksum,
  output int          mismatch_count,
  output int          checksums_due
);

  logic [16:0] ones_sum;
  logic [2:0]  seg_pos;
  logic [15:0] due_checksums[$];

  function automatic logic [16:0] end_around(input logic [31:0] v);
    logic [31:0] t;
    t = {16'd0, v[15:0]} + {16'd0, v[31:16]};
    t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
    return t[16:0];
  endfunction

  always @(posedge clk) begin : track
    logic [31:0] acc;
    logic [15:0] word;
    logic [15:0] want;
    if (!rst_n) begin
      ones_sum = '0;
      seg_pos = '0;
      due_checksums.delete();
      mismatch_count = 0;
    end else begin
      if (in_push && !in_full) begin
        if (in_first_word) begin
          acc = {16'd0, in_src_addr[31:16]} + {16'd0, in_src_addr[15:0]}
              + {16'd0, in_dst_addr[31:16]} + {16'd0, in_dst_addr[15:0]}
              + {24'd0, in_protocol} + {16'd0, in_segment_length};
          seg_pos = '0;
        end else begin
          acc = {15'd0, ones_sum};
        end
        word = in_data_word;
        if (in_last_word && in_odd_tail) word[7:0] = 8'h00;
        // checksum field counts as zero
        if (seg_pos == CKSUM_FIELD_POS) word = '0;
        ones_sum = end_around(acc + {16'd0, word});
        if (seg_pos < POS_SATURATE) seg_pos = seg_pos + 3'd1;
        if (in_last_word) due_checksums.push_back(~ones_sum[15:0]);
      end
      if (out_pop && !out_empty) begin
        if (due_checksums.size() == 0) begin
          $error("checksum popped with none due: actual %h", out_checksum);
          mismatch_count++;
        end else begin
          want = due_checksums.pop_front();
          if (want !== out_checksum) begin
            $error("checksum mismatch: expected %h, actual %h", want, out_checksum);
            mismatch_count++;
          end
        end
      end
    end
    checksums_due = due_checksums.size();
  end

endmodule

// ===== tb/udp_checksum_pseudo_header_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_checksum_pseudo_header_test
// Feeds UDP segments word by word into the checksum block: a directed set of
// corner segments, then random well-formed and broken segments, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module udp_checksum_pseudo_header_test;

  localparam int RANDOM_WORDS = 1350;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [7:0]  in_protocol = '0;
  logic [15:0] in_segment_length = '0;
  logic [15:0] in_data_word = '0;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic        in_odd_tail = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_checksum;

  int mismatch_count;
  int checksums_due;
  int words_sent;
  int idle_cycles;
  bit send_burst;
  bit pop_burst;

  always #10 clk = ~clk;

  udp_checksum_pseudo_header u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_src_addr       (in_src_addr),
    .in_dst_addr       (in_dst_addr),
    .in_protocol       (in_protocol),
    .in_segment_length (in_segment_length),
    .in_data_word      (in_data_word),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_odd_tail       (in_odd_tail),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_checksum      (out_checksum)
  );

  udp_checksum_pseudo_header_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_src_addr       (in_src_addr),
    .in_dst_addr       (in_dst_addr),
    .in_protocol       (in_protocol),
    .in_segment_length (in_segment_length),
    .in_data_word      (in_data_word),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_odd_tail       (in_odd_tail),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_checksum      (out_checksum),
    .mismatch_count    (mismatch_count),
    .checksums_due     (checksums_due)
  );

  task automatic send_word(input logic [31:0] src, input logic [31:0] dst,
                           input logic [7:0] proto, input logic [15:0] len,
                           input logic [15:0] word, input logic first,
                           input logic last, input logic odd);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_src_addr       <= src;
    in_dst_addr       <= dst;
    in_protocol       <= proto;
    in_segment_length <= len;
    in_data_word      <= word;
    in_first_word     <= first;
    in_last_word      <= last;
    in_odd_tail       <= odd;
    do @(posedge clk); while (in_full);
    words_sent++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'hffff;
      1:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_segment();
    int          kind;
    int          nwords;
    int          restart_at;
    logic        odd_seg;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] len;
    logic        first;
    logic        last;
    logic        odd;
    kind       = $urandom_range(0, 9);
    nwords     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                             : $urandom_range(1, 12);
    restart_at = $urandom_range(1, nwords);
    odd_seg    = 1'($urandom_range(0, 1));
    src        = $urandom;
    dst        = $urandom;
    proto      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd17;
    len        = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : 16'(2 * nwords - int'(odd_seg));
    send_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nwords; i++) begin
      first = (i == 0);
      last  = (i == nwords - 1);
      odd   = last ? odd_seg : 1'($urandom);
      case (kind)
        7: first = 1'b0;
        8: first = (i == 0) || (i == restart_at);
        9: begin
          first = ($urandom_range(0, 5) == 0);
          last  = ($urandom_range(0, 3) == 0);
          odd   = 1'($urandom_range(0, 1));
        end
        default: ;
      endcase
      if (i == 0 || first) send_word(src, dst, proto, len, pick_word(), first, last, odd);
      else send_word($urandom, $urandom, 8'($urandom), 16'($urandom), pick_word(),
                     first, last, odd);
    end
  endtask

  // result side: random stalls with occasional runs of back-to-back pops
  initial begin : drain
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) pop_burst = !pop_burst;
      stall = pop_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    words_sent = 0;
    send_burst = 1'b0;
    pop_burst  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // words before any first word keep adding onto the reset sum
    send_word('0, '0, '0, '0, 16'h1234, 1'b0, 1'b0, 1'b0);
    send_word('1, '1, '1, '1, 16'habcd, 1'b0, 1'b1, 1'b1);
    // word after a last word without a new first word
    send_word('0, '0, '0, '0, 16'hffff, 1'b0, 1'b1, 1'b0);
    // single-word segments: all ones, all zeros, sum folding to zero checksum
    send_word('1, '1, '1, '1, 16'hffff, 1'b1, 1'b1, 1'b0);
    send_word('0, '0, '0, '0, 16'h0000, 1'b1, 1'b1, 1'b0);
    send_word(32'hffff0000, '0, '0, '0, 16'h0000, 1'b1, 1'b1, 1'b1);
    // typical segment, stale checksum field, odd tail
    send_word(32'hc0a80001, 32'hc0a800c7, 8'd17, 16'd11, 16'h1f90, 1'b1, 1'b0, 1'b1);
    send_word('0, '0, '0, '0, 16'h0035, 1'b0, 1'b0, 1'b1);
    send_word('0, '0, '0, '0, 16'h000b, 1'b0, 1'b0, 1'b0);
    send_word('0, '0, '0, '0, 16'hffff, 1'b0, 1'b0, 1'b0);
    send_word('0, '0, '0, '0, 16'h6869, 1'b0, 1'b0, 1'b1);
    send_word('0, '0, '0, '0, 16'h21ff, 1'b0, 1'b1, 1'b1);
    // long segment past position saturation, length below minimum
    send_word(32'h0a000001, 32'hffffffff, 8'hff, 16'd0, 16'hffff, 1'b1, 1'b0, 1'b0);
    for (int i = 1; i < 9; i++) begin
      send_word('1, '1, '1, '1, (i == 3) ? 16'h8001 : 16'hffff, 1'b0, i == 8, 1'b0);
    end

    while (words_sent < RANDOM_WORDS + 21) send_segment();
    in_push <= 1'b0;

    while (checksums_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
